>>> design/tpba_pkg.sv
// Shared types, codes and constants for the two-pool bitmap slot allocator.
package tpba_pkg;

  localparam int SLOT_W     = 3;
  localparam int MARK_W     = 4;
  localparam int MARK_DEPTH = 16;
  localparam int OFFSET_W   = 9;

  localparam int DEF_SMALL_SLOTS = 8;
  localparam int DEF_LARGE_SLOTS = 8;
  localparam int DEF_SMALL_BYTES = 16;
  localparam int DEF_LARGE_BYTES = 32;

  localparam logic CMD_ALLOC  = 1'b0;
  localparam logic CMD_FREE   = 1'b1;
  localparam logic SIZE_SMALL = 1'b0;
  localparam logic SIZE_LARGE = 1'b1;

  typedef struct packed {
    logic              command;
    logic              size_class;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic                granted;
    logic [SLOT_W-1:0]   slot_out;
    logic                from_other_pool;
    logic [OFFSET_W-1:0] byte_offset;
  } rsp_t;

endpackage

>>> design/tpba_lowest.sv
// Priority encoder: index of the lowest set bit of a free vector.
module tpba_lowest import tpba_pkg::*; #(
  parameter int N = DEF_SMALL_SLOTS
) (
  input  logic [N-1:0]      free,
  output logic              found,
  output logic [SLOT_W-1:0] idx
);

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (free[i]) begin
        found = 1'b1;
        idx   = SLOT_W'(i);
      end
    end
  end

endmodule

>>> design/two_pool_bitmap_slot_allocator.sv
// Top level: request register, bitmap/mark update logic and result register.
//
// One transaction is accepted at every clock edge where start is high; busy
// is always low. Each transaction yields exactly one result, presented on rsp
// with done high for one cycle once it has gone through the request register
// and then the result register. Every transaction takes one pass through the
// priority encoders over the occupancy maps, so the block sustains one
// transaction per cycle. The receiver cannot stall the result.
module two_pool_bitmap_slot_allocator import tpba_pkg::*; #(
  parameter int SMALL_SLOTS = DEF_SMALL_SLOTS,
  parameter int LARGE_SLOTS = DEF_LARGE_SLOTS,
  parameter int SMALL_BYTES = DEF_SMALL_BYTES,
  parameter int LARGE_BYTES = DEF_LARGE_BYTES
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam logic [MARK_W-1:0] MarkBase   = MARK_W'(SMALL_SLOTS);
  localparam logic [31:0]       SmallBytes = 32'(SMALL_BYTES);
  localparam logic [31:0]       LargeBytes = 32'(LARGE_BYTES);
  localparam logic [31:0]       LargeBase  = 32'(SMALL_SLOTS * SMALL_BYTES);

  logic                   in_valid;
  req_t                   in_q;
  logic [SMALL_SLOTS-1:0] small_occ, small_next;
  logic [LARGE_SLOTS-1:0] large_occ, large_next;
  logic [MARK_DEPTH-1:0]  marks, marks_next;
  rsp_t                   rsp_next;

  logic                   small_found, large_found, pair_found;
  logic [SLOT_W-1:0]      small_idx, large_idx, pair_idx;
  logic [SMALL_SLOTS-2:0] pair_free;

  assign busy      = 1'b0;
  assign pair_free = ~small_occ[SMALL_SLOTS-2:0] & ~small_occ[SMALL_SLOTS-1:1];

  tpba_lowest #(.N(SMALL_SLOTS)) u_small (
    .free (~small_occ),
    .found(small_found),
    .idx  (small_idx)
  );

  tpba_lowest #(.N(LARGE_SLOTS)) u_large (
    .free (~large_occ),
    .found(large_found),
    .idx  (large_idx)
  );

  tpba_lowest #(.N(SMALL_SLOTS - 1)) u_pair (
    .free (pair_free),
    .found(pair_found),
    .idx  (pair_idx)
  );

  always_comb begin
    logic [MARK_W-1:0] small_mi;
    logic [MARK_W-1:0] large_mi;
    logic              mark;

    small_next = small_occ;
    large_next = large_occ;
    marks_next = marks;
    rsp_next   = '0;
    small_mi   = {1'b0, in_q.slot};
    large_mi   = MarkBase + {1'b0, in_q.slot};
    mark       = 1'b0;

    if (in_valid) begin
      if (in_q.command == CMD_FREE) begin
        rsp_next.granted  = 1'b1;
        rsp_next.slot_out = in_q.slot;
        if (in_q.size_class == SIZE_SMALL) begin
          mark = marks[small_mi];
          if (!mark) begin
            for (int i = 0; i < SMALL_SLOTS; i++) begin
              if (int'(in_q.slot) == i) small_next[i] = 1'b0;
            end
          end else begin
            for (int i = 0; i < LARGE_SLOTS; i++) begin
              if (int'(in_q.slot) == i) large_next[i] = 1'b0;
            end
            marks_next[small_mi] = 1'b0;
          end
        end else begin
          mark = marks[large_mi];
          if (!mark) begin
            for (int i = 0; i < LARGE_SLOTS; i++) begin
              if (int'(in_q.slot) == i) large_next[i] = 1'b0;
            end
          end else begin
            for (int i = 0; i < SMALL_SLOTS; i++) begin
              if (int'(in_q.slot) == i || int'(in_q.slot) + 1 == i) small_next[i] = 1'b0;
            end
            marks_next[large_mi] = 1'b0;
          end
        end
        rsp_next.from_other_pool = mark;
      end else if (in_q.size_class == SIZE_SMALL) begin
        if (small_found) begin
          small_next[small_idx]          = 1'b1;
          marks_next[{1'b0, small_idx}]  = 1'b0;
          rsp_next.granted               = 1'b1;
          rsp_next.slot_out              = small_idx;
          rsp_next.byte_offset           = OFFSET_W'(SmallBytes * 32'(small_idx));
        end else if (large_found) begin
          large_next[large_idx]          = 1'b1;
          marks_next[{1'b0, large_idx}]  = 1'b1;
          rsp_next.granted               = 1'b1;
          rsp_next.from_other_pool       = 1'b1;
          rsp_next.slot_out              = large_idx;
          rsp_next.byte_offset           =
            OFFSET_W'(LargeBase + LargeBytes * 32'(large_idx));
        end
      end else begin
        if (large_found) begin
          large_next[large_idx]                  = 1'b1;
          marks_next[MarkBase + {1'b0, large_idx}] = 1'b0;
          rsp_next.granted                       = 1'b1;
          rsp_next.slot_out                      = large_idx;
          rsp_next.byte_offset                   =
            OFFSET_W'(LargeBase + LargeBytes * 32'(large_idx));
        end else if (pair_found) begin
          for (int i = 0; i < SMALL_SLOTS; i++) begin
            if (int'(pair_idx) == i || int'(pair_idx) + 1 == i) small_next[i] = 1'b1;
          end
          marks_next[MarkBase + {1'b0, pair_idx}] = 1'b1;
          rsp_next.granted                        = 1'b1;
          rsp_next.from_other_pool                = 1'b1;
          rsp_next.slot_out                       = pair_idx;
          rsp_next.byte_offset                    = OFFSET_W'(SmallBytes * 32'(pair_idx));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      done      <= 1'b0;
      small_occ <= '0;
      large_occ <= '0;
      marks     <= '0;
    end else begin
      in_valid  <= start && !busy;
      done      <= in_valid;
      small_occ <= small_next;
      large_occ <= large_next;
      marks     <= marks_next;
    end
  end

  always_ff @(posedge clk) begin
    in_q <= req;
    rsp  <= rsp_next;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("accepted transaction did not complete two cycles later");

  a_small_grow: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_q.command == CMD_ALLOC && in_q.size_class == SIZE_SMALL && small_found
    |=> $countones(small_occ) == $past($countones(small_occ)) + 1)
    else $error("small allocation did not take exactly one small slot");

  a_refused_clean: assert property (@(posedge clk) disable iff (rst)
    done && !rsp.granted |-> rsp.slot_out == '0 && rsp.byte_offset == '0 &&
    !rsp.from_other_pool)
    else $error("refused allocation carries non-zero fields");

  a_refused_stable: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_q.command == CMD_ALLOC && !rsp_next.granted
    |=> $stable(small_occ) && $stable(large_occ) && $stable(marks))
    else $error("refused allocation changed allocator state");
`endif

endmodule

>>> verif/two_pool_bitmap_slot_allocator_tb.sv
// Self-checking bench for the two-pool allocator: directed table, then random bursts.
module two_pool_bitmap_slot_allocator_tb;
  import tpba_pkg::*;

  localparam int PLAN_ROWS   = 25;
  localparam int RAND_ITEMS  = 1400;
  localparam int QUIET_LIMIT = 500;
  localparam int LARGE_BASE  = DEF_SMALL_SLOTS * DEF_SMALL_BYTES;
  localparam bit [7:0] SMALL_MASK = 8'((1 << DEF_SMALL_SLOTS) - 1);
  localparam bit [7:0] LARGE_MASK = 8'((1 << DEF_LARGE_SLOTS) - 1);
  localparam rsp_t NO_SPACE = '0;

  typedef struct packed {
    req_t req;
    bit   fixed;
    rsp_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  // allocator state as the bench sees it
  bit [7:0]            small_map = '0;
  bit [7:0]            large_map = '0;
  bit [MARK_DEPTH-1:0] marks = '0;

  rsp_t grants_due[$];
  req_t held[$];
  int   errors = 0;
  int   accepted = 0;
  int   fallbacks = 0;
  int   refusals = 0;
  int   frees = 0;
  int   quiet = 0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{'{CMD_ALLOC, SIZE_SMALL, 3'd0}, 1'b1, '{1'b1, 3'd0, 1'b0, 9'd0}},
    '{'{CMD_ALLOC, SIZE_LARGE, 3'd7}, 1'b1, '{1'b1, 3'd0, 1'b0, 9'd128}},
    '{'{CMD_FREE,  SIZE_SMALL, 3'd0}, 1'b1, '{1'b1, 3'd0, 1'b0, 9'd0}},
    '{'{CMD_FREE,  SIZE_LARGE, 3'd0}, 1'b1, '{1'b1, 3'd0, 1'b0, 9'd0}},
    '{'{CMD_FREE,  SIZE_SMALL, 3'd5}, 1'b1, '{1'b1, 3'd5, 1'b0, 9'd0}},
    '{'{CMD_FREE,  SIZE_LARGE, 3'd7}, 1'b1, '{1'b1, 3'd7, 1'b0, 9'd0}},
    '{'{CMD_ALLOC, SIZE_LARGE, 3'd1}, 1'b0, NO_SPACE},
    '{'{CMD_ALLOC, SIZE_LARGE, 3'd2}, 1'b0, NO_SPACE},
    '{'{CMD_ALLOC, SIZE_LARGE, 3'd3}, 1'b0, NO_SPACE},
    '{'{CMD_ALLOC, SIZE_LARGE, 3'd4}, 1'b0, NO_SPACE},
    '{'{CMD_ALLOC, SIZE_LARGE, 3'd5}, 1'b0, NO_SPACE},
    '{'{CMD_ALLOC, SIZE_LARGE, 3'd6}, 1'b0, NO_SPACE},
    '{'{CMD_ALLOC, SIZE_LARGE, 3'd7}, 1'b0, NO_SPACE},
    '{'{CMD_ALLOC, SIZE_LARGE, 3'd0}, 1'b0, NO_SPACE},
    '{'{CMD_ALLOC, SIZE_LARGE, 3'd5}, 1'b0, NO_SPACE},
    '{'{CMD_ALLOC, SIZE_LARGE, 3'd2}, 1'b0, NO_SPACE},
    '{'{CMD_ALLOC, SIZE_SMALL, 3'd7}, 1'b0, NO_SPACE},
    '{'{CMD_ALLOC, SIZE_LARGE, 3'd3}, 1'b0, NO_SPACE},
    '{'{CMD_ALLOC, SIZE_SMALL, 3'd1}, 1'b0, NO_SPACE},
    '{'{CMD_ALLOC, SIZE_SMALL, 3'd6}, 1'b1, NO_SPACE},
    '{'{CMD_ALLOC, SIZE_LARGE, 3'd4}, 1'b1, NO_SPACE},
    '{'{CMD_FREE,  SIZE_LARGE, 3'd2}, 1'b0, NO_SPACE},
    '{'{CMD_FREE,  SIZE_SMALL, 3'd4}, 1'b0, NO_SPACE},
    '{'{CMD_ALLOC, SIZE_LARGE, 3'd0}, 1'b0, NO_SPACE},
    '{'{CMD_FREE,  SIZE_LARGE, 3'd7}, 1'b0, NO_SPACE}
  };

  two_pool_bitmap_slot_allocator uut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int first_clear(bit [7:0] map, int n);
    for (int i = 0; i < n; i++) begin
      if (!map[i]) return i;
    end
    return -1;
  endfunction

  function automatic int first_clear_pair(bit [7:0] map, int n);
    for (int i = 0; i < n - 1; i++) begin
      if (!map[i] && !map[i+1]) return i;
    end
    return -1;
  endfunction

  function automatic int large_mark(int s);
    return (DEF_SMALL_SLOTS + s) % MARK_DEPTH;
  endfunction

  // updates the bitmaps and marks for one transaction, returns the grant
  function automatic rsp_t allocate_or_free(req_t r);
    rsp_t o;
    int   loc;
    int   mi;
    o = '0;
    if (r.command == CMD_FREE) begin
      o.granted  = 1'b1;
      o.slot_out = r.slot;
      if (r.size_class == SIZE_SMALL) begin
        o.from_other_pool = marks[r.slot];
        if (!marks[r.slot]) begin
          small_map[r.slot] = 1'b0;
        end else begin
          large_map[r.slot] = 1'b0;
          marks[r.slot] = 1'b0;
        end
      end else begin
        mi = large_mark(int'(r.slot));
        o.from_other_pool = marks[mi];
        if (!marks[mi]) begin
          large_map[r.slot] = 1'b0;
        end else begin
          small_map = small_map & ~8'(3 << r.slot);
          marks[mi] = 1'b0;
        end
      end
      small_map &= SMALL_MASK;
      large_map &= LARGE_MASK;
      frees++;
    end else if (r.size_class == SIZE_SMALL) begin
      loc = first_clear(small_map, DEF_SMALL_SLOTS);
      if (loc >= 0) begin
        small_map[loc] = 1'b1;
        marks[loc % MARK_DEPTH] = 1'b0;
        o.granted = 1'b1;
        o.slot_out = 3'(loc);
        o.byte_offset = 9'(DEF_SMALL_BYTES * loc);
      end else begin
        loc = first_clear(large_map, DEF_LARGE_SLOTS);
        if (loc >= 0) begin
          large_map[loc] = 1'b1;
          marks[loc % MARK_DEPTH] = 1'b1;
          o = '{1'b1, 3'(loc), 1'b1, 9'(LARGE_BASE + DEF_LARGE_BYTES * loc)};
        end
      end
    end else begin
      loc = first_clear(large_map, DEF_LARGE_SLOTS);
      if (loc >= 0) begin
        large_map[loc] = 1'b1;
        marks[large_mark(loc)] = 1'b0;
        o = '{1'b1, 3'(loc), 1'b0, 9'(LARGE_BASE + DEF_LARGE_BYTES * loc)};
      end else begin
        loc = first_clear_pair(small_map, DEF_SMALL_SLOTS);
        if (loc >= 0) begin
          small_map = (small_map | 8'(3 << loc)) & SMALL_MASK;
          marks[large_mark(loc)] = 1'b1;
          o = '{1'b1, 3'(loc), 1'b1, 9'(DEF_SMALL_BYTES * loc)};
        end
      end
    end
    if (r.command == CMD_ALLOC) begin
      if (!o.granted) refusals++;
      else if (o.from_other_pool) fallbacks++;
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (errors < 30)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // drive one transaction and hold start until it is taken
  task automatic issue(input req_t r, input bit fixed, input rsp_t want);
    rsp_t grant;
    req   <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    grant = allocate_or_free(r);
    grants_due.push_back(fixed ? want : grant);
    accepted++;
    if (r.command == CMD_FREE) begin
      for (int k = 0; k < held.size(); k++) begin
        if (held[k] == r) begin
          held.delete(k);
          break;
        end
      end
    end else if (grant.granted) begin
      held.push_back('{CMD_FREE, r.size_class, grant.slot_out});
    end
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // allocations at alloc_pct percent; the rest are mostly frees of live handles, some at random handles
  function automatic req_t next_request(int alloc_pct);
    req_t r;
    r.command    = CMD_FREE;
    r.size_class = 1'($urandom_range(1));
    r.slot       = 3'($urandom_range(7));
    if ($urandom_range(99) < alloc_pct) r.command = CMD_ALLOC;
    else if (held.size() != 0 && $urandom_range(9) < 8)
      r = held[$urandom_range(held.size() - 1)];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (grants_due.size() == 0) begin
        report_mismatch("unexpected result", 16'(rsp), 16'(0));
      end else begin
        rsp_t want;
        want = grants_due.pop_front();
        if (rsp.granted !== want.granted)
          report_mismatch("granted", 16'(rsp.granted), 16'(want.granted));
        if (rsp.slot_out !== want.slot_out)
          report_mismatch("slot_out", 16'(rsp.slot_out), 16'(want.slot_out));
        if (rsp.from_other_pool !== want.from_other_pool)
          report_mismatch("from_other_pool", 16'(rsp.from_other_pool),
                          16'(want.from_other_pool));
        if (rsp.byte_offset !== want.byte_offset)
          report_mismatch("byte_offset", 16'(rsp.byte_offset), 16'(want.byte_offset));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) quiet = 0;
    else quiet = quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int burst;
    int alloc_pct;
    int rand_sent;
    rand_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[i]) begin
      issue(plan[i].req, plan[i].fixed, plan[i].want);
      if ($urandom_range(3) == 0) pause($urandom_range(1, 3));
    end
    while (rand_sent < RAND_ITEMS) begin
      burst = $urandom_range(1, 40);
      case ($urandom_range(2))
        0: begin
          alloc_pct = 85;
        end
        1: begin
          alloc_pct = 50;
        end
        default: begin
          alloc_pct = 25;
        end
      endcase
      for (int b = 0; b < burst && rand_sent < RAND_ITEMS; b++) begin
        issue(next_request(alloc_pct), 1'b0, NO_SPACE);
        rand_sent++;
      end
      if ($urandom_range(3) != 0) pause($urandom_range(1, 8));
    end
    start <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Ran %0d transactions: %0d frees, %0d fallback grants, %0d refused allocations",
             accepted, frees, fallbacks, refusals);
    $display("Mismatches: %0d", errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> two_pool_bitmap_slot_allocator.f
design/tpba_pkg.sv
design/tpba_lowest.sv
design/two_pool_bitmap_slot_allocator.sv
verif/two_pool_bitmap_slot_allocator_tb.sv
